FILE: src/jcce_pkg.sv
`default_nettype none

package jcce_pkg;

   localparam int KEY_LEN = 15;
   localparam int KEY_LAST = KEY_LEN - 1;
   localparam logic [7:0] CHAR_QUOTE = 8'h22;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB = 8'h09;
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_NINE = 8'h39;
   localparam logic [11:0] CODE_MAX = 12'd255;
   localparam logic [11:0] RADIX = 12'd10;

   // The key, a quoted field name followed by a colon, from its first byte to its last.
   localparam logic [7:0] KEY_BYTES [KEY_LEN] = '{
      8'h22, 8'h63, 8'h6f, 8'h6d, 8'h6d, 8'h61, 8'h6e, 8'h64,
      8'h5f, 8'h63, 8'h6f, 8'h64, 8'h65, 8'h22, 8'h3a
   };

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic       found_ok;
      logic [7:0] code_value;
   } rsp_type;

   // Classified byte as it travels through the queue.
   typedef struct packed {
      logic [KEY_LEN-1:0] key_hit;
      logic               is_blank;
      logic               is_digit;
      logic [3:0]         digit;
      logic               last;
   } class_type;

   typedef enum logic [2:0] {
      PH_SEARCH = 3'd0,
      PH_BLANKS = 3'd1,
      PH_DIGITS = 3'd2,
      PH_ENDED  = 3'd3,
      PH_FAILED = 3'd4
   } phase_type;

endpackage

`default_nettype wire

FILE: src/jcce_front.sv
`default_nettype none

module jcce_front (
   input  wire jcce_pkg::req_type   req_data,
   output jcce_pkg::class_type      cls_data
);
   import jcce_pkg::*;

   logic [7:0] b;
   logic [7:0] offset;

   assign b = req_data.data_byte;
   assign offset = b - CHAR_ZERO;

   always_comb begin
      for (int i = 0; i < KEY_LEN; i++) begin
         cls_data.key_hit[i] = (b == KEY_BYTES[i]);
      end
      cls_data.is_blank = (b == CHAR_SPACE) || (b == CHAR_TAB);
      cls_data.is_digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
      cls_data.digit = offset[3:0];
      cls_data.last = req_data.last_byte;
   end

endmodule

`default_nettype wire

FILE: src/jcce_fifo.sv
`default_nettype none

module jcce_fifo #(
   parameter int DEPTH = 4
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      push_valid,
   output logic                     push_ready,
   input  wire jcce_pkg::class_type push_data,
   output logic                     pop_valid,
   input  wire                      pop_ready,
   output jcce_pkg::class_type      pop_data
);
   import jcce_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   class_type        entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data = entries_ff[rd_ptr_ff];
   assign push = push_valid && push_ready;
   assign pop = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

FILE: src/jcce_back.sv
`default_nettype none

module jcce_back (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      cls_valid,
   output logic                     cls_ready,
   input  wire jcce_pkg::class_type cls_data,
   output logic                     rsp_valid,
   input  wire                      rsp_ready,
   output jcce_pkg::rsp_type        rsp_data
);
   import jcce_pkg::*;

   phase_type  phase_ff, phase_in;
   logic [3:0] match_ff, match_in;
   logic [7:0] number_ff, number_in;
   logic       seen_ff, seen_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_data_ff, rsp_data_in;
   logic       slot_free, take;
   logic [11:0] acc;
   logic       ok;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   // A byte that closes a message needs the output slot; others never wait.
   assign cls_ready = !cls_data.last || slot_free;
   assign take = cls_valid && cls_ready;
   assign acc = 12'(number_ff) * RADIX + 12'(cls_data.digit);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   always_comb begin
      phase_in = phase_ff;
      match_in = match_ff;
      number_in = number_ff;
      seen_in = seen_ff;
      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;
      rsp_data_in = rsp_data_ff;
      ok = 1'b0;

      if (take) begin
         unique case (phase_ff)
            PH_SEARCH: begin
               if (cls_data.key_hit[match_ff]) begin
                  if (match_ff == 4'(KEY_LAST)) begin
                     phase_in = PH_BLANKS;
                     match_in = '0;
                  end else begin
                     match_in = match_ff + 1'b1;
                  end
               end else if (match_ff == 4'(KEY_LAST) && cls_data.key_hit[1]) begin
                  // The closing quote may open a new key: restart past "c.
                  match_in = 4'd2;
               end else if (cls_data.key_hit[0]) begin
                  match_in = 4'd1;
               end else begin
                  match_in = '0;
               end
            end
            PH_BLANKS, PH_DIGITS: begin
               if (cls_data.is_digit) begin
                  phase_in = PH_DIGITS;
                  if (acc > CODE_MAX) begin
                     phase_in = PH_FAILED;
                     number_in = '0;
                  end else begin
                     number_in = acc[7:0];
                     seen_in = 1'b1;
                  end
               end else if (phase_ff == PH_DIGITS) begin
                  phase_in = PH_ENDED;
               end else if (!cls_data.is_blank) begin
                  phase_in = PH_FAILED;
               end
            end
            PH_ENDED: begin
               phase_in = PH_ENDED;
            end
            default: begin
               phase_in = PH_FAILED;
            end
         endcase

         if (cls_data.last) begin
            ok = ((phase_in == PH_DIGITS) || (phase_in == PH_ENDED)) && seen_in;
            rsp_valid_in = 1'b1;
            rsp_data_in.found_ok = ok;
            rsp_data_in.code_value = ok ? number_in : 8'd0;
            phase_in = PH_SEARCH;
            match_in = '0;
            number_in = '0;
            seen_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SEARCH;
         match_ff <= '0;
         number_ff <= '0;
         seen_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         match_ff <= match_in;
         number_ff <= number_in;
         seen_ff <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

FILE: src/json_command_code_extractor.sv
`default_nettype none

// Scans a byte stream for the first occurrence of the quoted command-code key
// and its colon, skips spaces and tabs after it and reads a decimal code of at
// most 255. Every message yields one result word on its last byte: found_ok with
// the code, or found_ok low and a zero code when the key is missing, no digit
// follows or the value overflows.
// One byte is accepted per cycle; the classifier feeds a QUEUE_DEPTH-word
// queue and the parser drains it at one word per cycle, so bytes stall only
// while a finished result waits in the output register and the queue is full.
// A result word becomes valid once its last byte has passed through the queue
// and the parser has written the result into the output register.
module json_command_code_extractor #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_ready,
   input  wire jcce_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire                    rsp_ready,
   output jcce_pkg::rsp_type      rsp_data
);
   import jcce_pkg::*;

   class_type front_cls;
   class_type queue_cls;
   logic      queue_valid;
   logic      queue_ready;

   jcce_front u_front (
      .req_data (req_data),
      .cls_data (front_cls)
   );

   jcce_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_valid),
      .push_ready (req_ready),
      .push_data  (front_cls),
      .pop_valid  (queue_valid),
      .pop_ready  (queue_ready),
      .pop_data   (queue_cls)
   );

   jcce_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cls_valid (queue_valid),
      .cls_ready (queue_ready),
      .cls_data  (queue_cls),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
